@@ rtl/core/cau_pkg.sv @@
// Shared types and constants of the complex arithmetic unit.
// Used by every module in rtl/core; depends on nothing.
package cau_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int QD = 4;
	localparam int QAW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CONJ = 3'd4,
		OP_MOD = 3'd5
	} op_e;

	typedef enum logic [1:0] {
		CL_DIRECT = 2'd0,
		CL_MUL = 2'd1,
		CL_DIV = 2'd2,
		CL_MOD = 2'd3
	} cls_e;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic [2:0] req_type;
		logic signed [DW-1:0] a_re;
		logic signed [DW-1:0] a_im;
		logic signed [DW-1:0] b_re;
		logic signed [DW-1:0] b_im;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] res_re;
		logic signed [DW-1:0] res_im;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		cls_e cls;
		req_t req;
	} entry_t;

endpackage

@@ rtl/core/complex_arith_unit.sv @@
// Complex ALU, signed Q16.16: add, sub, conjugate, multiply, modulus and divide; divide
// yields one quotient bit per cycle, both parts at once. The back end finishes each beat
// before it takes the next; a 4-entry queue absorbs bursts at one beat a cycle while busy
// is low. The result is valid on done for one cycle; arst_n clears the state machines,
// queue pointers and valid flags.
module complex_arith_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cau_pkg::req_t req,
	output logic done,
	output cau_pkg::res_t res
);

	logic push, pop, nonempty;
	logic [cau_pkg::QCW-1:0] fill;
	cau_pkg::entry_t wentry, rentry;

	cau_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.fill(fill), .push(push), .entry(wentry)
	);

	cau_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wentry), .pop(pop),
		.rdata(rentry), .nonempty(nonempty), .fill(fill)
	);

	cau_back u_back (
		.clk(clk), .arst_n(arst_n), .nonempty(nonempty), .entry(rentry), .pop(pop),
		.done(done), .res(res)
	);

endmodule

@@ rtl/core/cau_front.sv @@
// Front end: accepts request beats, classifies them and registers them.
// Depends on cau_pkg; feeds cau_fifo.
module cau_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cau_pkg::req_t req,
	input logic [cau_pkg::QCW-1:0] fill,
	output logic push,
	output cau_pkg::entry_t entry
);

	logic vld_s1;
	cau_pkg::entry_t ent_s1;
	cau_pkg::cls_e cls;

	always_comb begin
		case (req.req_type)
			cau_pkg::OP_MUL: cls = cau_pkg::CL_MUL;
			cau_pkg::OP_DIV: cls = cau_pkg::CL_DIV;
			cau_pkg::OP_MOD: cls = cau_pkg::CL_MOD;
			default: cls = cau_pkg::CL_DIRECT;
		endcase
	end

	assign busy = fill >= cau_pkg::QCW'(cau_pkg::QD - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			ent_s1.cls <= cls;
			ent_s1.req <= req;
		end
	end

	assign push = vld_s1;
	assign entry = ent_s1;

endmodule

@@ rtl/core/cau_fifo.sv @@
// Short queue between the front end and the execution back end.
// Depends on cau_pkg.
module cau_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cau_pkg::entry_t wdata,
	input logic pop,
	output cau_pkg::entry_t rdata,
	output logic nonempty,
	output logic [cau_pkg::QCW-1:0] fill
);

	cau_pkg::entry_t mem_q [cau_pkg::QD];
	logic [cau_pkg::QAW-1:0] wp_q;
	logic [cau_pkg::QAW-1:0] rp_q;
	logic [cau_pkg::QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	assign rdata = mem_q[rp_q];
	assign nonempty = cnt_q != '0;
	assign fill = cnt_q;

endmodule

@@ rtl/core/cau_back.sv @@
// Back end: executes queued requests with a shared multiplier bank and
// iterative divide and square root units. Depends on cau_pkg.
module cau_back (
	input logic clk,
	input logic arst_n,
	input logic nonempty,
	input cau_pkg::entry_t entry,
	output logic pop,
	output logic done,
	output cau_pkg::res_t res
);

	localparam int DW = cau_pkg::DW;
	localparam int FB = cau_pkg::FB;
	localparam int PW = 2 * DW;
	localparam int W = PW + 1;
	localparam int N = PW + FB;
	localparam int CW = $clog2(N + 1);
	localparam int SW = DW + 3;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_PROD = 5'b00100,
		S_DIV = 5'b01000,
		S_SQRT = 5'b10000
	} state_e;

	state_e state_q;
	cau_pkg::entry_t cur_q;
	logic [CW-1:0] cnt_q;
	logic signed [PW-1:0] p_q [4];
	logic [PW-1:0] den_q;
	logic [N-1:0] nr_q, ni_q;
	logic [PW-1:0] rr_q, ri_q;
	logic nneg_q, ineg_q;
	logic [PW-1:0] sq_src_q;
	logic [SW-1:0] sq_rem_q;
	logic [DW-1:0] root_q;
	logic done_q;
	cau_pkg::res_t res_q;

	logic signed [DW-1:0] mx [4];
	logic signed [DW-1:0] my [4];
	logic signed [PW-1:0] mp [4];
	logic signed [W-1:0] sum_a, sum_b;
	logic [W-1:0] mag_a, mag_b;
	logic [PW:0] tr_r, tr_i;
	logic [SW-1:0] sq_tr, sq_trial;
	logic [DW:0] sr, si, qr, qi;
	logic [PW:0] den_sum;

	function automatic logic [W-1:0] ext_d(input logic [DW-1:0] v);
		ext_d = {{(W-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic [W-1:0] ext_p(input logic [PW-1:0] v);
		ext_p = {{(W-PW){v[PW-1]}}, v};
	endfunction

	function automatic logic [DW:0] sat_w(input logic [W-1:0] v);
		logic [W-DW:0] hi;
		hi = v[W-1:DW-1];
		if ((&hi) || !(|hi)) begin
			sat_w = {1'b0, v[DW-1:0]};
		end else begin
			sat_w = {1'b1, v[W-1], {(DW-1){!v[W-1]}}};
		end
	endfunction

	function automatic logic [DW:0] sat_q(input logic [N-1:0] q, input logic neg);
		logic [DW-1:0] lo;
		lo = q[DW-1:0];
		if (neg) begin
			if ((|q[N-1:DW]) || (q[DW-1] && (|q[DW-2:0]))) begin
				sat_q = {1'b1, 1'b1, {(DW-1){1'b0}}};
			end else begin
				sat_q = {1'b0, -lo};
			end
		end else begin
			if (|q[N-1:DW-1]) begin
				sat_q = {1'b1, 1'b0, {(DW-1){1'b1}}};
			end else begin
				sat_q = {1'b0, lo};
			end
		end
	endfunction

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mx[k] = '0;
			my[k] = '0;
		end
		if (state_q == S_PROD) begin
			mx[0] = cur_q.req.b_re;
			my[0] = cur_q.req.b_re;
			mx[1] = cur_q.req.b_im;
			my[1] = cur_q.req.b_im;
		end else if (cur_q.cls == cau_pkg::CL_MOD) begin
			mx[0] = cur_q.req.a_re;
			my[0] = cur_q.req.a_re;
			mx[1] = cur_q.req.a_im;
			my[1] = cur_q.req.a_im;
		end else begin
			mx[0] = cur_q.req.a_re;
			my[0] = cur_q.req.b_re;
			mx[1] = cur_q.req.a_im;
			my[1] = cur_q.req.b_im;
			mx[2] = cur_q.req.a_im;
			my[2] = cur_q.req.b_re;
			mx[3] = cur_q.req.a_re;
			my[3] = cur_q.req.b_im;
		end
		for (int k = 0; k < 4; k++) begin
			mp[k] = mx[k] * my[k];
		end
	end

	always_comb begin
		if (cur_q.cls == cau_pkg::CL_MUL) begin
			sum_a = ext_p(p_q[0]) - ext_p(p_q[1]);
			sum_b = ext_p(p_q[2]) + ext_p(p_q[3]);
		end else begin
			sum_a = ext_p(p_q[0]) + ext_p(p_q[1]);
			sum_b = ext_p(p_q[2]) - ext_p(p_q[3]);
		end
		mag_a = sum_a[W-1] ? -sum_a : sum_a;
		mag_b = sum_b[W-1] ? -sum_b : sum_b;
		den_sum = {1'b0, mp[0]} + {1'b0, mp[1]};
		tr_r = {rr_q, nr_q[N-1]};
		tr_i = {ri_q, ni_q[N-1]};
		sq_tr = {sq_rem_q[SW-3:0], sq_src_q[PW-1:PW-2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sr = sat_w(ext_d(cur_q.req.a_re) + ext_d(cur_q.req.b_re));
		si = sat_w(ext_d(cur_q.req.a_im) + ext_d(cur_q.req.b_im));
		qr = sat_q(nr_q, nneg_q);
		qi = sat_q(ni_q, ineg_q);
		case (cur_q.req.req_type)
			cau_pkg::OP_SUB: begin
				sr = sat_w(ext_d(cur_q.req.a_re) - ext_d(cur_q.req.b_re));
				si = sat_w(ext_d(cur_q.req.a_im) - ext_d(cur_q.req.b_im));
			end
			cau_pkg::OP_MUL: begin
				sr = sat_w(sum_a >>> FB);
				si = sat_w(sum_b >>> FB);
			end
			cau_pkg::OP_CONJ: begin
				sr = {1'b0, cur_q.req.a_re};
				si = sat_w(-ext_d(cur_q.req.a_im));
			end
			cau_pkg::OP_MOD: begin
				sr = root_q[DW-1] ? {1'b1, 1'b0, {(DW-1){1'b1}}} : {1'b0, root_q};
				si = '0;
			end
			cau_pkg::OP_ADD: begin
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
	end

	assign pop = (state_q == S_IDLE) && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (nonempty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cur_q.cls == cau_pkg::CL_DIRECT) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					if (cur_q.cls == cau_pkg::CL_DIV) begin
						state_q <= S_DIV;
					end else if (cur_q.cls == cau_pkg::CL_MOD) begin
						state_q <= S_SQRT;
					end else begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV, S_SQRT: begin
					if (den_q == '0 && state_q == S_DIV || cnt_q == '0) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= entry;
		end
		if (state_q == S_EXEC) begin
			for (int k = 0; k < 4; k++) begin
				p_q[k] <= mp[k];
			end
			res_q.res_re <= sr[DW-1:0];
			res_q.res_im <= si[DW-1:0];
			res_q.status <= (sr[DW] || si[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
		if (state_q == S_PROD) begin
			res_q.res_re <= sr[DW-1:0];
			res_q.res_im <= si[DW-1:0];
			res_q.status <= (sr[DW] || si[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			den_q <= den_sum[PW-1:0];
			nr_q <= {mag_a[PW-1:0], {FB{1'b0}}};
			ni_q <= {mag_b[PW-1:0], {FB{1'b0}}};
			nneg_q <= sum_a[W-1];
			ineg_q <= sum_b[W-1];
			rr_q <= '0;
			ri_q <= '0;
			sq_src_q <= sum_a[PW-1:0];
			sq_rem_q <= '0;
			root_q <= '0;
			cnt_q <= (cur_q.cls == cau_pkg::CL_DIV) ? CW'(N) : CW'(DW);
		end
		if (state_q == S_DIV) begin
			if (den_q == '0) begin
				res_q.res_re <= '0;
				res_q.res_im <= '0;
				res_q.status <= cau_pkg::ST_DIVZ;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (tr_r >= {1'b0, den_q}) begin
					rr_q <= PW'(tr_r - {1'b0, den_q});
					nr_q <= {nr_q[N-2:0], 1'b1};
				end else begin
					rr_q <= tr_r[PW-1:0];
					nr_q <= {nr_q[N-2:0], 1'b0};
				end
				if (tr_i >= {1'b0, den_q}) begin
					ri_q <= PW'(tr_i - {1'b0, den_q});
					ni_q <= {ni_q[N-2:0], 1'b1};
				end else begin
					ri_q <= tr_i[PW-1:0];
					ni_q <= {ni_q[N-2:0], 1'b0};
				end
			end else begin
				res_q.res_re <= qr[DW-1:0];
				res_q.res_im <= qi[DW-1:0];
				res_q.status <= (qr[DW] || qi[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end
		if (state_q == S_SQRT) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				sq_src_q <= {sq_src_q[PW-3:0], 2'b00};
				if (sq_tr >= sq_trial) begin
					sq_rem_q <= sq_tr - sq_trial;
					root_q <= {root_q[DW-2:0], 1'b1};
				end else begin
					sq_rem_q <= sq_tr;
					root_q <= {root_q[DW-2:0], 1'b0};
				end
			end else begin
				res_q.res_re <= sr[DW-1:0];
				res_q.res_im <= '0;
				res_q.status <= sr[DW] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end
	end

	assign done = done_q;
	assign res = res_q;

`ifndef ASSERT_OFF
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status == cau_pkg::ST_DIVZ |-> res_q.res_re == '0 && res_q.res_im == '0)
		else $error("divide by zero result is not zero");
	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == S_EXEC)
		else $error("popped beat not executed");
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE ##1 !done_q)
		else $error("result strobes back to back");
`endif

endmodule
